FILE: rtl/core/assert_macros.svh
// assertion macros shared by the hasher rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on clock, off during reset
`define SHA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// same-cycle implication, sampled on clock, off during reset
`define SHA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/sha256s_pkg.sv
// types, constants and round functions of the sha-256 stream hasher
package sha256s_pkg;

   localparam int unsigned HASH_WORDS = 8;
   localparam int unsigned ROUNDS     = 64;
   localparam int unsigned SCHED_TAPS = 16;

   localparam logic [5:0] FILL_LAST = 6'd63;
   localparam logic [5:0] LEN_START = 6'd56;
   localparam logic [5:0] ROUND_LAST = 6'd63;
   localparam logic [7:0] PAD_BYTE  = 8'h80;
   localparam logic [1:0] WORD_LAST = 2'd3;

   localparam logic [31:0] INIT_HASH [HASH_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINAL,
      ST_PAD,
      ST_EMIT
   } ctrl_state_type;

   // source of the byte shifted into the block window
   typedef enum logic [1:0] {
      SEL_MSG,
      SEL_MARK,
      SEL_ZERO,
      SEL_LEN
   } byte_sel_type;

   typedef struct packed {
      logic         shift_en;
      byte_sel_type sel;
      logic         count_en;
      logic         round_en;
      logic         final_en;
      logic         init_en;
      logic [1:0]   word_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic [5:0] fill;
      logic       round_last;
   } dp_sts_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

FILE: rtl/core/sha256s_req_if.sv
// request channel: one message byte with its flags per word
interface sha256s_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_message;

   modport source (output valid, data_byte, byte_present, end_of_message, input ready);
   modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

FILE: rtl/core/sha256s_rsp_if.sv
// response channel: one 64-bit digest slice per word
interface sha256s_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_word;
   logic [1:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: rtl/core/sha256s_datapath.sv
// sha-256 datapath: block window, schedule, round logic, hash and length registers
`include "assert_macros.svh"

module sha256s_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  sha256s_pkg::dp_cmd_type cmd,
   input  logic [7:0]             data_byte,
   output sha256s_pkg::dp_sts_type sts,
   output logic [63:0]            digest_word
);
   import sha256s_pkg::*;

   logic [31:0] win_ff   [SCHED_TAPS];
   logic [31:0] win_in   [SCHED_TAPS];
   logic [31:0] hash_ff  [HASH_WORDS];
   logic [31:0] hash_in  [HASH_WORDS];
   logic [31:0] work_ff  [HASH_WORDS];
   logic [31:0] work_in  [HASH_WORDS];
   logic [63:0] len_ff;
   logic [63:0] len_in;
   logic [5:0]  fill_ff;
   logic [5:0]  fill_in;
   logic [5:0]  round_ff;
   logic [5:0]  round_in;
   logic [7:0]  byte_new;
   logic [7:0]  len_byte;
   logic [5:0]  len_shift;
   logic [31:0] sched_new;
   logic [31:0] t1;
   logic [31:0] t2;
   logic [2:0]  word_hi;

   // length bytes leave most significant first
   assign len_shift = {~fill_ff[2:0], 3'b000};
   assign len_byte  = 8'(len_ff >> len_shift);

   always_comb begin
      unique case (cmd.sel)
         SEL_MSG:  byte_new = data_byte;
         SEL_MARK: byte_new = PAD_BYTE;
         SEL_ZERO: byte_new = 8'h00;
         SEL_LEN:  byte_new = len_byte;
         default:  byte_new = 8'h00;
      endcase
   end

   assign sched_new = small_sigma1(win_ff[14]) + win_ff[9] + small_sigma0(win_ff[1]) + win_ff[0];

   assign t1 = work_ff[7] + big_sigma1(work_ff[4])
             + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
             + ROUND_K[round_ff] + win_ff[0];
   assign t2 = big_sigma0(work_ff[0])
             + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^ (work_ff[1] & work_ff[2]));

   always_comb begin
      for (int i = 0; i < SCHED_TAPS; i++) begin
         win_in[i] = win_ff[i];
      end
      if (cmd.shift_en) begin
         for (int i = 0; i < SCHED_TAPS - 1; i++) begin
            win_in[i] = {win_ff[i][23:0], win_ff[i+1][31:24]};
         end
         win_in[SCHED_TAPS-1] = {win_ff[SCHED_TAPS-1][23:0], byte_new};
      end else if (cmd.round_en) begin
         for (int i = 0; i < SCHED_TAPS - 1; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[SCHED_TAPS-1] = sched_new;
      end
   end

   always_comb begin
      for (int i = 0; i < HASH_WORDS; i++) begin
         if (cmd.init_en) begin
            hash_in[i] = INIT_HASH[i];
         end else if (cmd.final_en) begin
            hash_in[i] = hash_ff[i] + work_ff[i];
         end else begin
            hash_in[i] = hash_ff[i];
         end
      end
      if (cmd.round_en) begin
         work_in[0] = t1 + t2;
         work_in[1] = work_ff[0];
         work_in[2] = work_ff[1];
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3] + t1;
         work_in[5] = work_ff[4];
         work_in[6] = work_ff[5];
         work_in[7] = work_ff[6];
      end else begin
         // working set follows the hash so a block starts from it
         for (int i = 0; i < HASH_WORDS; i++) begin
            work_in[i] = hash_in[i];
         end
      end
   end

   always_comb begin
      fill_in  = cmd.shift_en ? fill_ff + 6'd1 : fill_ff;
      round_in = cmd.round_en ? round_ff + 6'd1 : '0;
      if (cmd.init_en) begin
         len_in = '0;
      end else if (cmd.shift_en && cmd.count_en) begin
         len_in = len_ff + 64'd8;
      end else begin
         len_in = len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HASH_WORDS; i++) begin
            hash_ff[i] <= INIT_HASH[i];
         end
         len_ff   <= '0;
         fill_ff  <= '0;
         round_ff <= '0;
      end else begin
         hash_ff  <= hash_in;
         len_ff   <= len_in;
         fill_ff  <= fill_in;
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      work_ff <= work_in;
   end

   assign word_hi        = {cmd.word_sel, 1'b0};
   assign digest_word    = {hash_ff[word_hi], hash_ff[word_hi + 3'd1]};
   assign sts.fill       = fill_ff;
   assign sts.round_last = (round_ff == ROUND_LAST);

   `SHA_ASSERT_IMP(a_round_on_full_block, cmd.round_en, fill_ff == '0, "rounds on a partial block")
   `SHA_ASSERT_IMP(a_round_starts_at_zero, $rose(cmd.round_en), round_ff == '0, "round count not cleared")
   `SHA_ASSERT_IMP(a_no_shift_in_rounds, cmd.round_en, !cmd.shift_en, "window shift during rounds")

endmodule

FILE: rtl/core/sha256s_ctrl.sv
// sha-256 controller: byte intake, padding sequence, round and digest sequencing
`include "assert_macros.svh"

module sha256s_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_byte_present,
   input  logic                    req_end_of_message,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_word_index,
   output logic                    rsp_last_word,
   output sha256s_pkg::dp_cmd_type cmd,
   input  sha256s_pkg::dp_sts_type sts
);
   import sha256s_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           closing_ff;
   logic           closing_in;
   logic           mark_ff;
   logic           mark_in;
   logic           spill_ff;
   logic           spill_in;
   logic           done_ff;
   logic           done_in;
   logic [1:0]     idx_ff;
   logic [1:0]     idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         closing_ff <= 1'b0;
         mark_ff    <= 1'b0;
         spill_ff   <= 1'b0;
         done_ff    <= 1'b0;
         idx_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         closing_ff <= closing_in;
         mark_ff    <= mark_in;
         spill_ff   <= spill_in;
         done_ff    <= done_in;
         idx_ff     <= idx_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      closing_in   = closing_ff;
      mark_in      = mark_ff;
      spill_in     = spill_ff;
      done_in      = done_ff;
      idx_in       = idx_ff;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      cmd          = '0;
      cmd.sel      = SEL_MSG;
      cmd.word_sel = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_byte_present) begin
                  cmd.shift_en = 1'b1;
                  cmd.count_en = 1'b1;
                  if (sts.fill == FILL_LAST) begin
                     state_in   = ST_ROUND;
                     closing_in = req_end_of_message;
                  end else if (req_end_of_message) begin
                     state_in   = ST_PAD;
                     closing_in = 1'b1;
                  end
               end else if (req_end_of_message) begin
                  state_in   = ST_PAD;
                  closing_in = 1'b1;
               end
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            if (sts.round_last) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            cmd.final_en = 1'b1;
            priority if (done_ff) begin
               state_in = ST_EMIT;
               idx_in   = '0;
            end else if (closing_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            cmd.shift_en = 1'b1;
            priority if (!mark_ff) begin
               cmd.sel  = SEL_MARK;
               mark_in  = 1'b1;
               // no room for the length behind a late mark, it goes in a fresh block
               spill_in = (sts.fill >= LEN_START) && (sts.fill != FILL_LAST);
            end else if (spill_ff || (sts.fill < LEN_START)) begin
               cmd.sel = SEL_ZERO;
               if (sts.fill == FILL_LAST) begin
                  spill_in = 1'b0;
               end
            end else begin
               cmd.sel = SEL_LEN;
               if (sts.fill == FILL_LAST) begin
                  done_in = 1'b1;
               end
            end
            if (sts.fill == FILL_LAST) begin
               state_in = ST_ROUND;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == WORD_LAST) begin
                  cmd.init_en = 1'b1;
                  closing_in  = 1'b0;
                  mark_in     = 1'b0;
                  done_in     = 1'b0;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_word_index = idx_ff;
   assign rsp_last_word  = (idx_ff == WORD_LAST);

   `SHA_ASSERT_NEXT(a_rounds_then_final, (state_ff == ST_ROUND) && sts.round_last,
      state_ff == ST_FINAL, "missing final add after last round")
   `SHA_ASSERT_IMP(a_length_after_mark, done_ff, mark_ff && closing_ff,
      "length placed without pad mark")
   `SHA_ASSERT_NEXT(a_idle_after_digest, rsp_valid && rsp_ready && rsp_last_word,
      (state_ff == ST_IDLE) && !closing_ff && !mark_ff, "message not restarted after digest")

endmodule

FILE: rtl/core/sha256_stream_hasher_core.sv
// sha-256 stream hasher top level: controller and datapath on two handshake channels
//
// takes one word per handshake on req_chan: a message byte (when byte_present is set)
// and an end_of_message mark. bytes shift into a 64-byte block window, one per cycle;
// while the window is filling the block accepts a word every cycle. the 64th byte of a
// block starts the compression: 64 rounds on a single round unit, then the hash add,
// during which req_chan is held off. end_of_message starts padding: the pad mark, zeros
// and the 64-bit big-endian bit count are shifted in one byte per cycle outside the one
// or two compressions, then the digest leaves on rsp_chan as four 64-bit words, word 0
// carrying h0:h1, last_word set on word 3. no new request word is taken from
// end_of_message until the last digest word is taken; after that the hasher holds the
// standard initial hash values and a zero length. an end_of_message with no byte since
// the previous digest gives the digest of the empty message, and the bit count wraps
// modulo 2^64.

module sha256_stream_hasher_core (
   input  logic          clock,
   input  logic          reset,
   sha256s_req_if.sink   req_chan,
   sha256s_rsp_if.source rsp_chan
);
   import sha256s_pkg::*;

   // controller drives the datapath, datapath reports fill and round status
   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   sha256s_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_chan.valid),
      .req_byte_present   (req_chan.byte_present),
      .req_end_of_message (req_chan.end_of_message),
      .req_ready          (req_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_word_index     (rsp_chan.word_index),
      .rsp_last_word      (rsp_chan.last_word),
      .cmd                (dp_cmd),
      .sts                (dp_sts)
   );

   // digest slice comes straight from the hash registers, stable while emitting
   sha256s_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (dp_cmd),
      .data_byte   (req_chan.data_byte),
      .sts         (dp_sts),
      .digest_word (rsp_chan.digest_word)
   );

endmodule
